// ===== hdl/ihw_pkg.sv =====
// Shared types, codes and constants for the ID3v2 frame header walker.
package ihw_pkg;

   typedef enum logic [2:0] {
      PH_MAGIC   = 3'd0,
      PH_SKIP    = 3'd1,
      PH_SIZE    = 3'd2,
      PH_HEADER  = 3'd3,
      PH_CONTENT = 3'd4,
      PH_DONE    = 3'd5,
      PH_REJECT  = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      EV_TAG_HEADER   = 2'd0,
      EV_FRAME_HEADER = 2'd1,
      EV_NOT_ID3      = 2'd2
   } event_kind_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [31:0] frame_id;
      logic [31:0] frame_size;
      logic [15:0] frame_flags;
      logic [28:0] tag_end;
   } result_type;

   localparam logic [3:0]  MAGIC_LEN      = 4'd3;
   localparam logic [3:0]  SKIP_LEN       = 4'd3;
   localparam logic [3:0]  SIZE_LEN       = 4'd4;
   localparam logic [3:0]  ID_LEN         = 4'd4;
   localparam logic [3:0]  ID_SIZE_LEN    = 4'd8;
   localparam logic [3:0]  HEADER_LEN     = 4'd10;
   localparam logic [28:0] TAG_HEADER_LEN = 29'd10;
   localparam logic [7:0]  SYNCSAFE_MASK  = 8'h7f;

   // The three magic bytes "ID3"; codes past the end mean nothing.
   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] val;
      case (idx)
         2'd0:    val = 8'h49;
         2'd1:    val = 8'h44;
         2'd2:    val = 8'h33;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

// ===== hdl/id3v2_frame_header_walker_unit.sv =====
// Takes one byte per cycle while req_stall is low and reports the tag header and each frame header.
// Latency: a result shows on rsp_valid in the cycle after its byte is accepted when no
// earlier result is still waiting; otherwise it follows that result.
// Throughput: one byte per cycle while req_stall is low; the step logic handles each byte combinationally.
// req_stall rises only when a result waits in the skid entry behind a stalled rsp.
// Reset: synchronous and active high; clears the parser to the magic check and empties
// the result register and the skid entry.
module id3v2_frame_header_walker_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_stream_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_kind,
   output logic [31:0] rsp_frame_id,
   output logic [31:0] rsp_frame_size,
   output logic [15:0] rsp_frame_flags,
   output logic [28:0] rsp_tag_end
);

   ihw_pkg::result_type step_res, out_res;
   logic step_valid, accept, full;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   ihw_core u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_data_byte),
      .stream_start (req_stream_start),
      .res_valid    (step_valid),
      .res          (step_res)
   );

   ihw_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept && step_valid),
      .in_res    (step_res),
      .full      (full),
      .out_valid (rsp_valid),
      .out_res   (out_res),
      .out_stall (rsp_stall)
   );

   assign rsp_event_kind  = out_res.event_kind;
   assign rsp_frame_id    = out_res.frame_id;
   assign rsp_frame_size  = out_res.frame_size;
   assign rsp_frame_flags = out_res.frame_flags;
   assign rsp_tag_end     = out_res.tag_end;

endmodule

// ===== hdl/ihw_core.sv =====
// Parser state registers and the per-byte step logic of the header walker.
module ihw_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         data_byte,
   input  logic               stream_start,
   output logic               res_valid,
   output ihw_pkg::result_type res
);

   ihw_pkg::phase_type phase_ff, phase_in, cur_phase;
   logic [31:0] pos_ff, pos_in, cur_pos, next_pos;
   logic [28:0] limit_ff, limit_in, cur_limit, tag_new;
   logic [3:0]  fi_ff, fi_in, cur_fi, fi_inc;
   logic [31:0] id_ff, id_in, cur_id;
   logic [31:0] size_ff, size_in, cur_size, size8;
   logic [27:0] size7;
   logic [15:0] flags_ff, flags_in, cur_flags, flags8;
   logic [31:0] left_ff, left_in, cur_left, left_dec;
   logic        magic_bad, skip_done, size_done, hdr_done;
   logic        in_tag_new, in_tag_cur;

   // A start marker restarts the parser before the byte is taken.
   assign cur_phase = stream_start ? ihw_pkg::PH_MAGIC : phase_ff;
   assign cur_pos   = stream_start ? 32'd0 : pos_ff;
   assign cur_limit = stream_start ? 29'd0 : limit_ff;
   assign cur_fi    = stream_start ? 4'd0  : fi_ff;
   assign cur_id    = stream_start ? 32'd0 : id_ff;
   assign cur_size  = stream_start ? 32'd0 : size_ff;
   assign cur_flags = stream_start ? 16'd0 : flags_ff;
   assign cur_left  = stream_start ? 32'd0 : left_ff;

   assign next_pos = (cur_pos == 32'hffff_ffff) ? cur_pos : cur_pos + 32'd1;
   assign fi_inc   = cur_fi + 4'd1;

   assign size7   = {cur_size[20:0], data_byte[6:0] & ihw_pkg::SYNCSAFE_MASK[6:0]};
   assign tag_new = {1'b0, size7} + ihw_pkg::TAG_HEADER_LEN;
   assign size8   = {cur_size[23:0], data_byte};
   assign flags8  = {cur_flags[7:0], data_byte};
   assign left_dec = (cur_left != 32'd0) ? cur_left - 32'd1 : cur_left;

   assign magic_bad = (cur_fi >= ihw_pkg::MAGIC_LEN) ||
                      (data_byte != ihw_pkg::magic_byte(cur_fi[1:0]));
   assign skip_done = (fi_inc >= ihw_pkg::SKIP_LEN);
   assign size_done = (fi_inc >= ihw_pkg::SIZE_LEN);
   assign hdr_done  = (fi_inc >= ihw_pkg::HEADER_LEN);

   assign in_tag_new = (next_pos < {3'd0, tag_new});
   assign in_tag_cur = (next_pos < {3'd0, cur_limit});

   // Next phase.
   always_comb begin
      phase_in = cur_phase;
      unique case (cur_phase)
         ihw_pkg::PH_MAGIC: begin
            if (magic_bad) begin
               phase_in = ihw_pkg::PH_REJECT;
            end else if (fi_inc == ihw_pkg::MAGIC_LEN) begin
               phase_in = ihw_pkg::PH_SKIP;
            end
         end
         ihw_pkg::PH_SKIP: begin
            if (skip_done) begin
               phase_in = ihw_pkg::PH_SIZE;
            end
         end
         ihw_pkg::PH_SIZE: begin
            if (size_done) begin
               phase_in = in_tag_new ? ihw_pkg::PH_HEADER : ihw_pkg::PH_DONE;
            end
         end
         ihw_pkg::PH_HEADER: begin
            if (hdr_done) begin
               if (size8 != 32'd0 && cur_fi >= ihw_pkg::ID_LEN &&
                   cur_fi < ihw_pkg::ID_SIZE_LEN) begin
                  phase_in = ihw_pkg::PH_CONTENT;
               end else if (cur_size != 32'd0 && cur_fi >= ihw_pkg::ID_SIZE_LEN) begin
                  phase_in = ihw_pkg::PH_CONTENT;
               end else begin
                  phase_in = in_tag_cur ? ihw_pkg::PH_HEADER : ihw_pkg::PH_DONE;
               end
            end
         end
         ihw_pkg::PH_CONTENT: begin
            if (left_dec == 32'd0) begin
               phase_in = in_tag_cur ? ihw_pkg::PH_HEADER : ihw_pkg::PH_DONE;
            end
         end
         ihw_pkg::PH_DONE, ihw_pkg::PH_REJECT: begin
            phase_in = cur_phase;
         end
         default: phase_in = cur_phase;
      endcase
   end

   // Counters, shift registers and the result of this byte.
   always_comb begin
      pos_in    = next_pos;
      limit_in  = cur_limit;
      fi_in     = cur_fi;
      id_in     = cur_id;
      size_in   = cur_size;
      flags_in  = cur_flags;
      left_in   = cur_left;
      res_valid = 1'b0;
      res       = '0;
      unique case (cur_phase)
         ihw_pkg::PH_MAGIC: begin
            if (magic_bad) begin
               res_valid      = 1'b1;
               res.event_kind = ihw_pkg::EV_NOT_ID3;
            end else begin
               fi_in = (fi_inc == ihw_pkg::MAGIC_LEN) ? 4'd0 : fi_inc;
            end
         end
         ihw_pkg::PH_SKIP: begin
            fi_in = skip_done ? 4'd0 : fi_inc;
         end
         ihw_pkg::PH_SIZE: begin
            if (size_done) begin
               limit_in       = tag_new;
               fi_in          = 4'd0;
               size_in        = 32'd0;
               res_valid      = 1'b1;
               res.event_kind = ihw_pkg::EV_TAG_HEADER;
               res.tag_end    = tag_new;
            end else begin
               fi_in   = fi_inc;
               size_in = {4'd0, size7};
            end
         end
         ihw_pkg::PH_HEADER: begin
            if (cur_fi < ihw_pkg::ID_LEN) begin
               id_in = {cur_id[23:0], data_byte};
            end else if (cur_fi < ihw_pkg::ID_SIZE_LEN) begin
               size_in = size8;
            end else begin
               flags_in = flags8;
            end
            fi_in = fi_inc;
            if (hdr_done) begin
               res_valid       = 1'b1;
               res.event_kind  = ihw_pkg::EV_FRAME_HEADER;
               res.frame_id    = id_in;
               res.frame_size  = size_in;
               res.frame_flags = flags_in;
               res.tag_end     = cur_limit;
               left_in         = size_in;
               fi_in           = 4'd0;
               id_in           = 32'd0;
               size_in         = 32'd0;
               flags_in        = 16'd0;
            end
         end
         ihw_pkg::PH_CONTENT: begin
            left_in = left_dec;
         end
         ihw_pkg::PH_DONE, ihw_pkg::PH_REJECT: begin
            left_in = cur_left;
         end
         default: left_in = cur_left;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ihw_pkg::PH_MAGIC;
         pos_ff   <= 32'd0;
         limit_ff <= 29'd0;
         fi_ff    <= 4'd0;
         id_ff    <= 32'd0;
         size_ff  <= 32'd0;
         flags_ff <= 16'd0;
         left_ff  <= 32'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         limit_ff <= limit_in;
         fi_ff    <= fi_in;
         id_ff    <= id_in;
         size_ff  <= size_in;
         flags_ff <= flags_in;
         left_ff  <= left_in;
      end
   end

endmodule

// ===== hdl/ihw_out_buf.sv =====
// Result register with a skid entry so the byte side keeps moving while a result waits.
module ihw_out_buf (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  ihw_pkg::result_type in_res,
   output logic               full,
   output logic               out_valid,
   output ihw_pkg::result_type out_res,
   input  logic               out_stall
);

   ihw_pkg::result_type out_ff, out_in, skid_ff, skid_in;
   logic out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic take;

   assign take      = out_valid_ff && !out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_res   = out_ff;

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         // No new item can arrive while the skid entry is occupied.
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || take) begin
            out_in       = in_res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = in_res;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule
